/* hw/rtl/cfla_pkg.sv */
// Shared constants, codes and control types of the chunked free-list allocator.
package cfla_pkg;

  localparam int POOL_ENTRIES = 1024;
  localparam int PTR_W        = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = PTR_W + 1;
  localparam int CHUNK_W      = 11;
  localparam int HANDLE_W     = 10;
  localparam int OUTST_W      = 11;
  localparam int TOTAL_W      = 32;
  localparam int LEN_W        = (CNT_W > CHUNK_W) ? CNT_W : CHUNK_W;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(512);
  localparam logic [OUTST_W-1:0] PEAK_MAX    = '1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CARVE,
    ST_POP_RD,
    ST_POP_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic free_do;
    logic pop_rd;
    logic carve_start;
    logic carve_step;
    logic pop_upd;
    logic exhaust;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic can_carve;
    logic carve_last;
  } stat_t;

endpackage

/* hw/rtl/cfla_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/cfla_dp.sv */
// Datapath: list head, carve pointer, counters, link memory and result registers.
module cfla_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfla_pkg::cmd_t                cmd,
  output cfla_pkg::stat_t               stat,
  input  logic [cfla_pkg::HANDLE_W-1:0] in_handle,
  input  logic                          cfg_wr,
  input  logic [cfla_pkg::CHUNK_W-1:0]  cfg_chunk_size,
  output logic [cfla_pkg::HANDLE_W-1:0] out_alloc_handle,
  output logic                          out_status,
  output logic [cfla_pkg::OUTST_W-1:0]  out_outstanding,
  output logic [cfla_pkg::OUTST_W-1:0]  out_high_water
);
  import cfla_pkg::*;

  logic [CHUNK_W-1:0]  chunk_r, chunk_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [CNT_W-1:0]    carved_r, carved_nxt;
  logic [PTR_W-1:0]    carve_ptr_r, carve_ptr_nxt;
  logic [CNT_W-1:0]    carve_end_r, carve_end_nxt;
  logic [TOTAL_W-1:0]  outst_r, outst_nxt;
  logic [OUTST_W-1:0]  peak_r, peak_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic                res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r;
  logic                out_status_r;
  logic [OUTST_W-1:0]  out_outst_r;
  logic [OUTST_W-1:0]  out_peak_r;

  logic [LEN_W-1:0]   chunk_eff, left, take;
  logic [CNT_W-1:0]   ptr_inc;
  logic               carve_last;
  logic               in_pool;
  logic [TOTAL_W-1:0] outst_inc;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr, mem_wdata, mem_rdata;

  // Chunk length: zero means one, clipped to what is left of the pool.
  assign chunk_eff  = (chunk_r == '0) ? LEN_W'(1) : LEN_W'(chunk_r);
  assign left       = LEN_W'(POOL_ENTRIES) - LEN_W'(carved_r);
  assign take       = (chunk_eff < left) ? chunk_eff : left;
  assign ptr_inc    = CNT_W'(carve_ptr_r) + CNT_W'(1);
  assign carve_last = (ptr_inc == carve_end_r);
  assign in_pool    = (32'(in_handle) < 32'(POOL_ENTRIES));
  assign outst_inc  = outst_r + TOTAL_W'(1);

  assign stat.head_valid = head_valid_r;
  assign stat.can_carve  = (carved_r < CNT_W'(POOL_ENTRIES));
  assign stat.carve_last = carve_last;

  // Link writes: carve links each entry to the next, last to itself; free to head or itself.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = carve_ptr_r;
    mem_wdata = carve_last ? carve_ptr_r : ptr_inc[PTR_W-1:0];
    if (cmd.carve_step) begin
      mem_we = 1'b1;
    end else if (cmd.free_do && in_pool) begin
      mem_we    = 1'b1;
      mem_waddr = PTR_W'(in_handle);
      mem_wdata = head_valid_r ? head_r : PTR_W'(in_handle);
    end
  end

  cfla_ram #(
    .WIDTH (PTR_W),
    .DEPTH (POOL_ENTRIES)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (cmd.pop_rd),
    .rd_addr (head_r),
    .rd_data (mem_rdata)
  );

  always_comb begin
    chunk_nxt      = cfg_wr ? cfg_chunk_size : chunk_r;
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    carved_nxt     = carved_r;
    carve_ptr_nxt  = carve_ptr_r;
    carve_end_nxt  = carve_end_r;
    outst_nxt      = outst_r;
    peak_nxt       = peak_r;
    res_handle_nxt = res_handle_r;
    res_status_nxt = res_status_r;

    if (cmd.free_do) begin
      res_handle_nxt = '0;
      res_status_nxt = STATUS_OK;
      if (in_pool) begin
        head_nxt       = PTR_W'(in_handle);
        head_valid_nxt = 1'b1;
        outst_nxt      = outst_r - TOTAL_W'(1);
      end
    end

    if (cmd.carve_start) begin
      carve_ptr_nxt = carved_r[PTR_W-1:0];
      carve_end_nxt = CNT_W'(LEN_W'(carved_r) + take);
    end

    if (cmd.carve_step) begin
      carve_ptr_nxt = ptr_inc[PTR_W-1:0];
      if (carve_last) begin
        head_nxt       = carved_r[PTR_W-1:0];
        head_valid_nxt = 1'b1;
        carved_nxt     = carve_end_r;
      end
    end

    if (cmd.pop_upd) begin
      if (mem_rdata == head_r) begin
        head_valid_nxt = 1'b0;
      end else begin
        head_nxt = mem_rdata;
      end
      res_handle_nxt = HANDLE_W'(head_r);
      res_status_nxt = STATUS_OK;
      outst_nxt      = outst_inc;
      if ((outst_inc > TOTAL_W'(peak_r)) && (peak_r != PEAK_MAX)) begin
        peak_nxt = peak_r + OUTST_W'(1);
      end
    end

    if (cmd.exhaust) begin
      res_handle_nxt = '0;
      res_status_nxt = STATUS_EXHAUSTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r      <= CHUNK_RESET;
      head_r       <= '0;
      head_valid_r <= 1'b0;
      carved_r     <= '0;
      outst_r      <= '0;
      peak_r       <= '0;
      out_peak_r   <= '0;
    end else begin
      chunk_r      <= chunk_nxt;
      head_r       <= head_nxt;
      head_valid_r <= head_valid_nxt;
      carved_r     <= carved_nxt;
      outst_r      <= outst_nxt;
      peak_r       <= peak_nxt;
      if (cmd.load_out) begin
        out_peak_r <= peak_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    carve_ptr_r  <= carve_ptr_nxt;
    carve_end_r  <= carve_end_nxt;
    res_handle_r <= res_handle_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load_out) begin
      out_handle_r <= res_handle_r;
      out_status_r <= res_status_r;
      out_outst_r  <= outst_r[OUTST_W-1:0];
    end
  end

  assign out_alloc_handle = out_handle_r;
  assign out_status       = out_status_r;
  assign out_outstanding  = out_outst_r;
  assign out_high_water   = out_peak_r;

endmodule

/* hw/rtl/cfla_ctrl.sv */
// Controller: sequences accept, carve, pop and result hand-off.
module cfla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_mode,
  output logic            out_valid,
  input  logic            out_ready,
  output cfla_pkg::cmd_t  cmd,
  input  cfla_pkg::stat_t stat
);
  import cfla_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_FREE) begin
            state_nxt = ST_DONE;
          end else if (stat.head_valid) begin
            state_nxt = ST_POP_UPD;
          end else if (stat.can_carve) begin
            state_nxt = ST_CARVE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CARVE: begin
        if (stat.carve_last) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD:  state_nxt = ST_POP_UPD;
      ST_POP_UPD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_FREE) begin
            cmd.free_do = 1'b1;
          end else if (stat.head_valid) begin
            cmd.pop_rd = 1'b1;
          end else if (stat.can_carve) begin
            cmd.carve_start = 1'b1;
          end else begin
            cmd.exhaust = 1'b1;
          end
        end
      end
      ST_CARVE:   cmd.carve_step = 1'b1;
      ST_POP_RD:  cmd.pop_rd     = 1'b1;
      ST_POP_UPD: cmd.pop_upd    = 1'b1;
      ST_DONE:    cmd.load_out   = slot_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/chunked_free_list_allocator_core.sv */
// Top level of the chunked free-list handle allocator.
// Hands out and takes back handles to a pool of POOL_ENTRIES equal entries. Free entries
// form a linked list held in a link RAM (one write and one registered read port). A free beat
// (mode 1) pushes its handle on the list at accept, then hands off the result; a handle
// outside the pool is answered but not pushed. An allocate beat (mode 0) reads the link of
// the list head through the registered read port of the link RAM, then pops the head. When
// the list is empty, the next chunk of never-carved entries (chunk_size of them, zero taken
// as one, clipped to what is left) is first linked in ascending order at one RAM write per
// cycle; once the whole pool is carved and the list is empty, allocate answers status 1 with
// handle 0. One item is in flight at a time; the result register lets the next beat start
// while a result still waits on out_ready. outstanding is allocations minus in-pool frees,
// wrapped to 11 bits; high_water climbs by one per allocate that tops it. The user must write
// chunk_size via the always-ready cfg channel only while idle; the block does not enforce it.
module chunked_free_list_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cfla_pkg::CHUNK_W-1:0]  cfg_chunk_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [cfla_pkg::HANDLE_W-1:0] in_handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cfla_pkg::HANDLE_W-1:0] out_alloc_handle,
  output logic                          out_status,
  output logic [cfla_pkg::OUTST_W-1:0]  out_outstanding,
  output logic [cfla_pkg::OUTST_W-1:0]  out_high_water
);
  import cfla_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Take register writes at any time; the user only writes while idle.
  assign cfg_ready = 1'b1;

  cfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cfla_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_handle        (in_handle),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_chunk_size   (cfg_chunk_size),
    .out_alloc_handle (out_alloc_handle),
    .out_status       (out_status),
    .out_outstanding  (out_outstanding),
    .out_high_water   (out_high_water)
  );

  // One beat at a time: after an accept the input side closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is still in flight");

  // Consume link data in the cycle after its read was issued.
  a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_upd |-> $past(cmd.pop_rd))
    else $error("pop update without a preceding link read");

  // The last carve write leaves a valid list head.
  a_carve_fills_list: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.carve_step && stat.carve_last) |=> stat.head_valid)
    else $error("carve finished with an empty free list");

  // High-water mark never falls.
  a_high_water_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_high_water >= $past(out_high_water)))
    else $error("high-water mark decreased");

endmodule
